>>> src/container_trace_classifier_core_defines.svh
// Assertion macros for the container trace classifier core.
// Used by the top level only; no other dependencies.
`ifndef CONTAINER_TRACE_CLASSIFIER_CORE_DEFINES_SVH
`define CONTAINER_TRACE_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTH
// Condition in this cycle implies a consequence in the same cycle.
`define CTC_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("ctc: same-cycle check failed");
// Condition in this cycle implies a consequence in the next cycle.
`define CTC_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("ctc: next-cycle check failed");
`else
`define CTC_ASSERT_NOW(label, clk, rst_n, cond, conseq)
`define CTC_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif

`endif

>>> src/ctc_pkg.sv
// Shared types, codes and helpers for the container trace classifier.
// No dependencies.
package ctc_pkg;

    localparam int VALUE_FIELD_BITS = 16;

    // Bit positions in the pass flags.
    localparam int PASS_STK  = 0;
    localparam int PASS_FIFO = 1;
    localparam int PASS_HEAP = 2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        VERDICT_IMPOSSIBLE = 3'd0,
        VERDICT_STACK      = 3'd1,
        VERDICT_QUEUE      = 3'd2,
        VERDICT_PRIO       = 3'd3,
        VERDICT_UNSURE     = 3'd4
    } t_verdict;

    typedef struct packed {
        logic                        kind;
        logic [VALUE_FIELD_BITS-1:0] value;
        logic                        last;
    } t_in_word;

    typedef struct packed {
        logic     stack_ok;
        logic     queue_ok;
        logic     heap_ok;
        t_verdict verdict;
        logic     overflow;
        logic     final_res;
    } t_out_word;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic stk_push;
        logic stk_pop;
        logic fifo_ins;
        logic fifo_pop;
        logic heap_ins;
        logic heap_pop;
    } t_cell_cmd;

    typedef struct packed {
        logic [2:0] pass;
        logic       ovf;
    } t_ctc_status;

    function automatic t_verdict f_verdict(input logic [2:0] pass);
        t_verdict res;
        unique case (pass)
            3'b000:  res = VERDICT_IMPOSSIBLE;
            3'b001:  res = VERDICT_STACK;
            3'b010:  res = VERDICT_QUEUE;
            3'b100:  res = VERDICT_PRIO;
            default: res = VERDICT_UNSURE;
        endcase
        return res;
    endfunction

endpackage

>>> src/container_trace_classifier_core.sv
// A result word is registered and is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle unless a held output result stalls the input; every
// word updates the whole cell row in the cycle it is accepted, with the head compare and
// the per-cell ordering compare of the priority list in that one path.
// Reset clears counts, overflow and the output valid flag and sets all pass flags;
// cell contents are not cleared and are only read below the matching count.
`include "container_trace_classifier_core_defines.svh"

module container_trace_classifier_core #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ctc_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ctc_pkg::t_out_word  o_out
);
    import ctc_pkg::*;

    // Values above the input field width are always zero, so store no more.
    localparam int W  = (VALUE_BITS < VALUE_FIELD_BITS) ? VALUE_BITS : VALUE_FIELD_BITS;
    localparam int CW = $clog2(DEPTH + 1);

    t_cell_cmd     cmd;
    t_ctc_status   status;
    logic [W-1:0]  value;
    logic [CW-1:0] fifo_cnt;
    logic [CW-1:0] heap_cnt;
    logic [W-1:0]  stk_q  [DEPTH];
    logic [W-1:0]  fifo_q [DEPTH];
    logic [W-1:0]  heap_q [DEPTH];
    logic          gt     [DEPTH];

    ctc_ctrl #(
        .DEPTH (DEPTH),
        .W     (W),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_stk_head  (stk_q[0]),
        .i_fifo_head (fifo_q[0]),
        .i_heap_head (heap_q[0]),
        .o_cmd       (cmd),
        .o_value     (value),
        .o_fifo_cnt  (fifo_cnt),
        .o_heap_cnt  (heap_cnt),
        .o_status    (status)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [W-1:0] prev_stk, prev_heap, next_stk, next_fifo, next_heap;
        logic         prev_gt;

        if (g == 0) begin : g_first
            assign prev_stk  = value;
            assign prev_heap = value;
            assign prev_gt   = 1'b0;
        end else begin : g_mid
            assign prev_stk  = stk_q[g-1];
            assign prev_heap = heap_q[g-1];
            assign prev_gt   = gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_end
            assign next_stk  = stk_q[g];
            assign next_fifo = fifo_q[g];
            assign next_heap = heap_q[g];
        end else begin : g_inner
            assign next_stk  = stk_q[g+1];
            assign next_fifo = fifo_q[g+1];
            assign next_heap = heap_q[g+1];
        end

        ctc_cell #(
            .W (W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_value     (value),
            .i_fifo_here (fifo_cnt == CW'(g)),
            .i_heap_occ  (CW'(g) < heap_cnt),
            .i_prev_gt   (prev_gt),
            .o_gt        (gt[g]),
            .i_prev_stk  (prev_stk),
            .i_next_stk  (next_stk),
            .i_next_fifo (next_fifo),
            .i_prev_heap (prev_heap),
            .i_next_heap (next_heap),
            .o_stk       (stk_q[g]),
            .o_fifo      (fifo_q[g]),
            .o_heap      (heap_q[g])
        );
    end

    `CTC_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in.last,
                     status.pass == 3'b111 && !status.ovf)
    `CTC_ASSERT_NEXT(a_fail_sticks, i_clk, i_rst_n,
                     i_in_valid && o_in_ready && !i_in.last && !status.pass[PASS_HEAP],
                     !status.pass[PASS_HEAP])
    `CTC_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)
    `CTC_ASSERT_NOW(a_two_pass_unsure, i_clk, i_rst_n,
                    o_out_valid && o_out.stack_ok && o_out.queue_ok,
                    o_out.verdict == VERDICT_UNSURE)

endmodule

>>> src/ctc_cell.sv
// One cell of the storage row: one stack entry, one queue entry and one
// entry of the sorted priority list. Depends on ctc_pkg.
module ctc_cell #(
    parameter int W = 16
) (
    input  logic                 i_clk,
    input  ctc_pkg::t_cell_cmd   i_cmd,
    input  logic [W-1:0]         i_value,
    input  logic                 i_fifo_here,
    input  logic                 i_heap_occ,
    input  logic                 i_prev_gt,
    output logic                 o_gt,
    input  logic [W-1:0]         i_prev_stk,
    input  logic [W-1:0]         i_next_stk,
    input  logic [W-1:0]         i_next_fifo,
    input  logic [W-1:0]         i_prev_heap,
    input  logic [W-1:0]         i_next_heap,
    output logic [W-1:0]         o_stk,
    output logic [W-1:0]         o_fifo,
    output logic [W-1:0]         o_heap
);
    import ctc_pkg::*;

    logic [W-1:0] r_stk, n_stk;
    logic [W-1:0] r_fifo, n_fifo;
    logic [W-1:0] r_heap, n_heap;

    // The priority list is kept in descending order, so the cells where the
    // new value is larger, and the free cells, form one run at the end of the row.
    assign o_gt = !i_heap_occ || (i_value > r_heap);

    always_comb begin
        n_stk  = r_stk;
        n_fifo = r_fifo;
        n_heap = r_heap;
        if (i_cmd.stk_push) begin
            n_stk = i_prev_stk;
        end else if (i_cmd.stk_pop) begin
            n_stk = i_next_stk;
        end
        if (i_cmd.fifo_ins && i_fifo_here) begin
            n_fifo = i_value;
        end else if (i_cmd.fifo_pop) begin
            n_fifo = i_next_fifo;
        end
        if (i_cmd.heap_ins && o_gt) begin
            n_heap = i_prev_gt ? i_prev_heap : i_value;
        end else if (i_cmd.heap_pop) begin
            n_heap = i_next_heap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stk  <= n_stk;
        r_fifo <= n_fifo;
        r_heap <= n_heap;
    end

    assign o_stk  = r_stk;
    assign o_fifo = r_fifo;
    assign o_heap = r_heap;

endmodule

>>> src/ctc_ctrl.sv
// Controller: counts, pass flags, overflow, head checks, the command for the
// cell row and the result register. Depends on ctc_pkg.
module ctc_ctrl #(
    parameter int DEPTH = 256,
    parameter int W     = 16,
    parameter int CW    = 9
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  ctc_pkg::t_in_word    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output ctc_pkg::t_out_word   o_out,
    input  logic [W-1:0]         i_stk_head,
    input  logic [W-1:0]         i_fifo_head,
    input  logic [W-1:0]         i_heap_head,
    output ctc_pkg::t_cell_cmd   o_cmd,
    output logic [W-1:0]         o_value,
    output logic [CW-1:0]        o_fifo_cnt,
    output logic [CW-1:0]        o_heap_cnt,
    output ctc_pkg::t_ctc_status o_status
);
    import ctc_pkg::*;

    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    logic [CW-1:0] r_stk_cnt, n_stk_cnt;
    logic [CW-1:0] r_fifo_cnt, n_fifo_cnt;
    logic [CW-1:0] r_heap_cnt, n_heap_cnt;
    logic [2:0]    r_pass, n_pass;
    logic          r_ovf, n_ovf;
    logic          r_out_valid;
    t_out_word     r_out;
    t_out_word     res;
    t_cell_cmd     cmd;
    logic          acc;
    logic [W-1:0]  value;

    assign value      = i_in.value[W-1:0];
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign acc        = i_in_valid && o_in_ready;

    always_comb begin
        n_stk_cnt  = r_stk_cnt;
        n_fifo_cnt = r_fifo_cnt;
        n_heap_cnt = r_heap_cnt;
        n_pass     = r_pass;
        n_ovf      = r_ovf;
        cmd        = '0;
        if (acc) begin
            if (i_in.kind == KIND_REMOVE) begin
                if (r_pass[PASS_STK]) begin
                    if (r_stk_cnt != '0 && i_stk_head == value) begin
                        cmd.stk_pop = 1'b1;
                        n_stk_cnt   = r_stk_cnt - ONE;
                    end else begin
                        n_pass[PASS_STK] = 1'b0;
                    end
                end
                if (r_pass[PASS_FIFO]) begin
                    if (r_fifo_cnt != '0 && i_fifo_head == value) begin
                        cmd.fifo_pop = 1'b1;
                        n_fifo_cnt   = r_fifo_cnt - ONE;
                    end else begin
                        n_pass[PASS_FIFO] = 1'b0;
                    end
                end
                if (r_pass[PASS_HEAP]) begin
                    if (r_heap_cnt != '0 && i_heap_head == value) begin
                        cmd.heap_pop = 1'b1;
                        n_heap_cnt   = r_heap_cnt - ONE;
                    end else begin
                        n_pass[PASS_HEAP] = 1'b0;
                    end
                end
            end else begin
                // A full live model drops the word and raises overflow.
                if (r_pass[PASS_STK]) begin
                    if (r_stk_cnt == FULL) begin
                        n_ovf = 1'b1;
                    end else begin
                        cmd.stk_push = 1'b1;
                        n_stk_cnt    = r_stk_cnt + ONE;
                    end
                end
                if (r_pass[PASS_FIFO]) begin
                    if (r_fifo_cnt == FULL) begin
                        n_ovf = 1'b1;
                    end else begin
                        cmd.fifo_ins = 1'b1;
                        n_fifo_cnt   = r_fifo_cnt + ONE;
                    end
                end
                if (r_pass[PASS_HEAP]) begin
                    if (r_heap_cnt == FULL) begin
                        n_ovf = 1'b1;
                    end else begin
                        cmd.heap_ins = 1'b1;
                        n_heap_cnt   = r_heap_cnt + ONE;
                    end
                end
            end
        end

        res.stack_ok  = n_pass[PASS_STK];
        res.queue_ok  = n_pass[PASS_FIFO];
        res.heap_ok   = n_pass[PASS_HEAP];
        res.verdict   = f_verdict(n_pass);
        res.overflow  = n_ovf;
        res.final_res = i_in.last;

        if (acc && i_in.last) begin
            n_stk_cnt  = '0;
            n_fifo_cnt = '0;
            n_heap_cnt = '0;
            n_pass     = 3'b111;
            n_ovf      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stk_cnt   <= '0;
            r_fifo_cnt  <= '0;
            r_heap_cnt  <= '0;
            r_pass      <= 3'b111;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_stk_cnt  <= n_stk_cnt;
            r_fifo_cnt <= n_fifo_cnt;
            r_heap_cnt <= n_heap_cnt;
            r_pass     <= n_pass;
            r_ovf      <= n_ovf;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;
    assign o_cmd           = cmd;
    assign o_value         = value;
    assign o_fifo_cnt      = r_fifo_cnt;
    assign o_heap_cnt      = r_heap_cnt;
    assign o_status.pass   = r_pass;
    assign o_status.ovf    = r_ovf;

endmodule
